### rtl/preset_bank_led_indicator_unit_macros.svh
// assertion macros for the port-level checker file
`ifndef PRESET_BANK_LED_INDICATOR_UNIT_MACROS_SVH
`define PRESET_BANK_LED_INDICATOR_UNIT_MACROS_SVH

// antecedent holds in a cycle, consequent must hold in that same cycle
`define PBLED_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("pbled assertion failed");

// antecedent holds in a cycle, consequent must hold in the next cycle
`define PBLED_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("pbled assertion failed");

`endif

### rtl/pbled_pkg.sv
// shared types, constants and a helper function for the led indicator unit
package pbled_pkg;

  localparam int unsigned IDX_W            = 8;
  localparam int unsigned ROW_N            = 4;
  localparam int unsigned LED_W            = ROW_N;
  localparam int unsigned CODE_W           = 4;
  localparam int unsigned CFG_IDX_W        = 2;
  localparam int unsigned CFG_DATA_W       = 1;
  localparam int unsigned BLINK_HALF_DEF   = 50;
  localparam int unsigned DIM_OFF_DEF      = 10;

  localparam logic [IDX_W-1:0] NONE_IDX = 8'hff;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PLAIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BAR   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROT   = 2'd2;

  typedef logic [IDX_W-1:0] idx_t;

  typedef enum logic [1:0] {
    LS_OFF   = 2'd0,
    LS_ON    = 2'd1,
    LS_BLINK = 2'd2,
    LS_DIM   = 2'd3
  } led_state_e;

  typedef led_state_e [ROW_N-1:0] row_state_t;

  typedef struct packed {
    logic blink;
    logic dim;
  } phase_t;

  // drive level of one led for its state and the current phases
  function automatic logic led_bit(led_state_e st, phase_t ph, logic dim_off);
    logic v;
    v = 1'b0;
    unique case (st)
      LS_ON:    v = 1'b1;
      LS_BLINK: v = ph.blink;
      LS_DIM:   v = ph.dim & ~dim_off;
      default:  v = 1'b0;
    endcase
    return v;
  endfunction

endpackage

### rtl/pbled_timer.sv
// blink and dim phase generators, advanced once per accepted item
module pbled_timer #(
  parameter int unsigned BLINK_HALF_TICKS = pbled_pkg::BLINK_HALF_DEF,
  parameter int unsigned DIM_OFF_TICKS    = pbled_pkg::DIM_OFF_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              adv_i,
  output pbled_pkg::phase_t phase_o
);
  import pbled_pkg::*;

  localparam int unsigned BlinkW = $clog2(BLINK_HALF_TICKS + 1);
  localparam int unsigned DimW   = $clog2(DIM_OFF_TICKS + 1);

  logic [BlinkW-1:0] blink_cnt_q, blink_cnt_d;
  logic [DimW-1:0]   dim_cnt_q, dim_cnt_d;
  logic              blink_q, blink_d;
  logic              dim_q, dim_d;

  always_comb begin
    blink_cnt_d = blink_cnt_q;
    blink_d     = blink_q;
    dim_cnt_d   = dim_cnt_q;
    dim_d       = dim_q;
    if (adv_i) begin
      if (blink_cnt_q == BlinkW'(BLINK_HALF_TICKS - 1)) begin
        blink_cnt_d = '0;
        blink_d     = ~blink_q;
      end else begin
        blink_cnt_d = blink_cnt_q + BlinkW'(1);
      end
      // dim is lit for one tick, then dark for DIM_OFF_TICKS ticks
      if (dim_cnt_q <= DimW'(1)) begin
        dim_d     = ~dim_q;
        dim_cnt_d = dim_q ? DimW'(DIM_OFF_TICKS) : DimW'(1);
      end else begin
        dim_cnt_d = dim_cnt_q - DimW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blink_cnt_q <= '0;
      blink_q     <= 1'b0;
      dim_cnt_q   <= '0;
      dim_q       <= 1'b0;
    end else begin
      blink_cnt_q <= blink_cnt_d;
      blink_q     <= blink_d;
      dim_cnt_q   <= dim_cnt_d;
      dim_q       <= dim_d;
    end
  end

  assign phase_o.blink = blink_q;
  assign phase_o.dim   = dim_q;

endmodule

### rtl/pbled_row.sv
// led states of one row of four positions in point or bar mode
module pbled_row (
  input  pbled_pkg::idx_t       now_i,
  input  pbled_pkg::idx_t       pend_i,
  input  pbled_pkg::idx_t       prev_i,
  input  logic                  plain_i,
  input  logic                  bar_i,
  output pbled_pkg::row_state_t state_o,
  output logic                  blink_o
);
  import pbled_pkg::*;

  logic [ROW_N-1:0] blink_pos;

  always_comb begin
    for (int p = 0; p < ROW_N; p++) begin
      blink_pos[p] = 1'b0;
      if (bar_i) begin
        state_o[p] = (IDX_W'(p) <= now_i) ? LS_ON : LS_OFF;
        if (!plain_i && prev_i == IDX_W'(p) && prev_i != now_i) begin
          state_o[p] = LS_DIM;
        end
      end else if (now_i == IDX_W'(p)) begin
        state_o[p] = LS_ON;
      end else if (pend_i == IDX_W'(p)) begin
        state_o[p]   = LS_BLINK;
        blink_pos[p] = 1'b1;
      end else if (prev_i == IDX_W'(p) && !plain_i) begin
        state_o[p] = LS_DIM;
      end else begin
        state_o[p] = LS_OFF;
      end
    end
  end

  assign blink_o = |blink_pos;

endmodule

### rtl/preset_bank_led_indicator_unit.sv
// preset/bank led indicator: two rows of four leds plus inverted selection code
// path: an accepted item is held in the input reg, then moves to the result reg
// once that is free or not stalled (input reg, result reg)
// throughput: one item per cycle; in_stall_o rises only when both regs are full
// and out_stall_i is high
// reset: async active low, clears valids, config registers and blink/dim timers
module preset_bank_led_indicator_unit #(
  parameter int unsigned BLINK_HALF_TICKS = pbled_pkg::BLINK_HALF_DEF,
  parameter int unsigned DIM_OFF_TICKS    = pbled_pkg::DIM_OFF_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [pbled_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [pbled_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  pbled_pkg::idx_t                    preset_now_i,
  input  pbled_pkg::idx_t                    preset_pending_i,
  input  pbled_pkg::idx_t                    preset_before_i,
  input  pbled_pkg::idx_t                    bank_now_i,
  input  pbled_pkg::idx_t                    bank_pending_i,
  input  pbled_pkg::idx_t                    bank_before_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [pbled_pkg::LED_W-1:0]        row_a_leds_o,
  output logic [pbled_pkg::LED_W-1:0]        row_b_leds_o,
  output logic [pbled_pkg::CODE_W-1:0]       selection_code_o
);
  import pbled_pkg::*;

  logic plain_q, bar_q, rot_q;

  logic   s1_valid_q, s1_valid_d;
  idx_t   pn_q, pp_q, pb_q, bn_q, bp_q, bb_q;
  phase_t ph_q;
  phase_t ph_now;

  logic              out_valid_q, out_valid_d;
  logic [LED_W-1:0]  row_a_q, row_a_d, row_b_q, row_b_d;
  logic [CODE_W-1:0] code_q, code_d;

  logic in_acc, s1_move;

  logic       edit, bar_sel, blink_p, blink_b, dim_off;
  row_state_t st_p, st_b;
  logic [ROW_N-1:0] v_p, v_b;
  idx_t       sel_p, sel_b;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plain_q <= 1'b0;
      bar_q   <= 1'b0;
      rot_q   <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PLAIN: plain_q <= cfg_data_i[0];
        CFG_BAR:   bar_q   <= cfg_data_i[0];
        CFG_ROT:   rot_q   <= cfg_data_i[0];
        default:   ;
      endcase
    end
  end

  // handshake
  assign s1_move    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc) begin
      s1_valid_d = 1'b1;
    end else if (s1_move) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_move) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // timers step per item; each item keeps the phases it was accepted with
  pbled_timer #(
    .BLINK_HALF_TICKS (BLINK_HALF_TICKS),
    .DIM_OFF_TICKS    (DIM_OFF_TICKS)
  ) u_timer (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (in_acc),
    .phase_o (ph_now)
  );

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pn_q <= preset_now_i;
      pp_q <= preset_pending_i;
      pb_q <= preset_before_i;
      bn_q <= bank_now_i;
      bp_q <= bank_pending_i;
      bb_q <= bank_before_i;
      ph_q <= ph_now;
    end
  end

  // led states
  assign edit    = (pp_q != NONE_IDX && pn_q != pp_q) || (bp_q != NONE_IDX && bn_q != bp_q);
  assign bar_sel = bar_q && !edit;

  pbled_row u_row_preset (
    .now_i   (pn_q),
    .pend_i  (pp_q),
    .prev_i  (pb_q),
    .plain_i (plain_q),
    .bar_i   (bar_sel),
    .state_o (st_p),
    .blink_o (blink_p)
  );

  pbled_row u_row_bank (
    .now_i   (bn_q),
    .pend_i  (bp_q),
    .prev_i  (bb_q),
    .plain_i (plain_q),
    .bar_i   (bar_sel),
    .state_o (st_b),
    .blink_o (blink_b)
  );

  // any blink in either row turns dim off
  assign dim_off = !bar_sel && (blink_p || blink_b);

  always_comb begin
    for (int p = 0; p < ROW_N; p++) begin
      v_p[p] = led_bit(st_p[p], ph_q, dim_off);
      v_b[p] = led_bit(st_b[p], ph_q, dim_off);
    end
    for (int p = 0; p < ROW_N; p++) begin
      if (rot_q) begin
        row_a_d[ROW_N-1-p] = v_b[p];
        row_b_d[ROW_N-1-p] = v_p[p];
      end else begin
        row_a_d[p] = v_p[p];
        row_b_d[p] = v_b[p];
      end
    end
  end

  // selection code prefers the pending pair
  assign sel_p  = (pp_q != NONE_IDX || bp_q != NONE_IDX) ? pp_q : pn_q;
  assign sel_b  = (pp_q != NONE_IDX || bp_q != NONE_IDX) ? bp_q : bn_q;
  assign code_d = {~sel_b[1:0], ~sel_p[1:0]};

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      row_a_q <= row_a_d;
      row_b_q <= row_b_d;
      code_q  <= code_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign row_a_leds_o     = row_a_q;
  assign row_b_leds_o     = row_b_q;
  assign selection_code_o = code_q;

endmodule

### rtl/pbled_checker.sv
// port-level checker for the led indicator unit and its bind
`include "preset_bank_led_indicator_unit_macros.svh"

module pbled_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic [7:0] preset_now_i,
  input logic [7:0] preset_pending_i,
  input logic [7:0] bank_now_i,
  input logic [7:0] bank_pending_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [3:0] row_a_leds_o,
  input logic [3:0] row_b_leds_o,
  input logic [3:0] selection_code_o
);
  import pbled_pkg::*;

  logic in_acc;
  logic no_pend;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign no_pend = (preset_pending_i == NONE_IDX) && (bank_pending_i == NONE_IDX);

  // a stalled result holds
  `PBLED_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(row_a_leds_o) && $stable(row_b_leds_o) && $stable(selection_code_o))

  // an accepted item with a free output path shows up as a valid result
  `PBLED_ASSERT_IMPLY(a_latency, clk_i, rst_ni, $past(rst_ni) && $past(rst_ni, 2) && $past(in_acc, 2) && !$past(out_stall_i), out_valid_o)

  // a result never appears without an accepted item before it
  `PBLED_ASSERT_IMPLY(a_no_invent, clk_i, rst_ni, $past(rst_ni) && $past(rst_ni, 2) && $rose(out_valid_o), $past(in_acc, 2))

  // without a pending selection the code is the inverted current pair
  `PBLED_ASSERT_IMPLY(a_code_now, clk_i, rst_ni, $past(rst_ni) && $past(rst_ni, 2) && $past(in_acc, 2) && $past(no_pend, 2) && !$past(out_stall_i), selection_code_o == {~$past(bank_now_i[1:0], 2), ~$past(preset_now_i[1:0], 2)})

endmodule

bind preset_bank_led_indicator_unit pbled_checker u_pbled_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .preset_now_i     (preset_now_i),
  .preset_pending_i (preset_pending_i),
  .bank_now_i       (bank_now_i),
  .bank_pending_i   (bank_pending_i),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .row_a_leds_o     (row_a_leds_o),
  .row_b_leds_o     (row_b_leds_o),
  .selection_code_o (selection_code_o)
);

### sim/led_indicator_checker.sv
// checker for the led indicator unit: predicts each tick's leds and compares the results
module led_indicator_checker
  import pbled_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  idx_t                  preset_now_i,
  input  idx_t                  preset_pending_i,
  input  idx_t                  preset_before_i,
  input  idx_t                  bank_now_i,
  input  idx_t                  bank_pending_i,
  input  idx_t                  bank_before_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic [LED_W-1:0]      row_a_leds_i,
  input  logic [LED_W-1:0]      row_b_leds_i,
  input  logic [CODE_W-1:0]     selection_code_i,
  output int                    fail_count_o,
  output int                    pending_o,
  output int                    checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [LED_W-1:0]  row_a;
    logic [LED_W-1:0]  row_b;
    logic [CODE_W-1:0] code;
  } led_result_t;

  led_result_t leds_due_q [$];
  led_result_t want;

  logic       plain_r;
  logic       bar_r;
  logic       rot_r;
  logic       blink_ph;
  logic [5:0] blink_cnt;
  logic       dim_ph;
  logic [3:0] dim_cnt;
  int         fails;
  int         checked;

  function automatic row_state_t point_row(input idx_t now, input idx_t pend, input idx_t prev);
    row_state_t st;
    for (int p = 0; p < ROW_N; p++) begin
      if (now == p) begin
        st[p] = LS_ON;
      end else if (pend == p) begin
        st[p] = LS_BLINK;
      end else if (prev == p) begin
        st[p] = plain_r ? LS_OFF : LS_DIM;
      end else begin
        st[p] = LS_OFF;
      end
    end
    return st;
  endfunction

  function automatic row_state_t bar_row(input idx_t now, input idx_t prev);
    row_state_t st;
    for (int p = 0; p < ROW_N; p++) begin
      st[p] = (p <= now) ? LS_ON : LS_OFF;
    end
    // previous beyond the row marks nothing
    if (!plain_r && prev != NONE_IDX && prev != now && prev < ROW_N) begin
      st[prev[1:0]] = LS_DIM;
    end
    return st;
  endfunction

  function automatic logic led_level(input led_state_e s);
    case (s)
      LS_ON:    return 1'b1;
      LS_BLINK: return blink_ph;
      LS_DIM:   return dim_ph;
      default:  return 1'b0;
    endcase
  endfunction

  function automatic led_result_t predict_leds(input idx_t pn, input idx_t pp, input idx_t pb,
                                               input idx_t bn, input idx_t bp, input idx_t bb);
    row_state_t  sp;
    row_state_t  sb;
    logic        editing;
    logic        any_blink;
    idx_t        selp;
    idx_t        selb;
    led_result_t r;
    editing = (pp != NONE_IDX && pp != pn) || (bp != NONE_IDX && bp != bn);
    if (bar_r && !editing) begin
      sp = bar_row(pn, pb);
      sb = bar_row(bn, bb);
    end else begin
      sp = point_row(pn, pp, pb);
      sb = point_row(bn, bp, bb);
      any_blink = 1'b0;
      for (int p = 0; p < ROW_N; p++) begin
        if (sp[p] == LS_BLINK || sb[p] == LS_BLINK) any_blink = 1'b1;
      end
      // a blinking led anywhere turns the dim ones off
      if (any_blink) begin
        for (int p = 0; p < ROW_N; p++) begin
          if (sp[p] == LS_DIM) sp[p] = LS_OFF;
          if (sb[p] == LS_DIM) sb[p] = LS_OFF;
        end
      end
    end
    r = '0;
    for (int p = 0; p < ROW_N; p++) begin
      if (rot_r) begin
        r.row_b[ROW_N-1-p] = led_level(sp[p]);
        r.row_a[ROW_N-1-p] = led_level(sb[p]);
      end else begin
        r.row_a[p] = led_level(sp[p]);
        r.row_b[p] = led_level(sb[p]);
      end
    end
    if (pp != NONE_IDX || bp != NONE_IDX) begin
      selp = pp;
      selb = bp;
    end else begin
      selp = pn;
      selb = bn;
    end
    r.code = {~selb[1:0], ~selp[1:0]};
    return r;
  endfunction

  // timers move after the tick's leds are formed
  function automatic void advance_timers();
    blink_cnt = blink_cnt + 6'd1;
    if (blink_cnt >= BLINK_HALF_DEF) begin
      blink_cnt = '0;
      blink_ph  = ~blink_ph;
    end
    if (dim_cnt <= 4'd1) begin
      dim_ph  = ~dim_ph;
      dim_cnt = dim_ph ? 4'd1 : 4'(DIM_OFF_DEF);
    end else begin
      dim_cnt = dim_cnt - 4'd1;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      leds_due_q.delete();
      plain_r      = 1'b0;
      bar_r        = 1'b0;
      rot_r        = 1'b0;
      blink_ph     = 1'b0;
      blink_cnt    = '0;
      dim_ph       = 1'b0;
      dim_cnt      = '0;
      fails        = 0;
      checked      = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
      checked_o    <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (leds_due_q.size() == 0) begin
          $error("result with no item waiting: row_a_leds %0h row_b_leds %0h selection_code %0h",
                 row_a_leds_i, row_b_leds_i, selection_code_i);
          fails++;
        end else begin
          want = leds_due_q.pop_front();
          checked++;
          if (row_a_leds_i !== want.row_a) begin
            $error("row_a_leds: expected %0h, got %0h", want.row_a, row_a_leds_i);
            fails++;
          end
          if (row_b_leds_i !== want.row_b) begin
            $error("row_b_leds: expected %0h, got %0h", want.row_b, row_b_leds_i);
            fails++;
          end
          if (selection_code_i !== want.code) begin
            $error("selection_code: expected %0h, got %0h", want.code, selection_code_i);
            fails++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        leds_due_q.push_back(predict_leds(preset_now_i, preset_pending_i, preset_before_i,
                                          bank_now_i, bank_pending_i, bank_before_i));
        advance_timers();
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_PLAIN: plain_r = cfg_data_i[0];
          CFG_BAR:   bar_r   = cfg_data_i[0];
          CFG_ROT:   rot_r   = cfg_data_i[0];
          default: ;
        endcase
      end
      fail_count_o <= fails;
      pending_o    <= leds_due_q.size();
      checked_o    <= checked;
    end
  end

endmodule

### sim/tb.sv
// testbench top for the led indicator unit: stimulus, receiver stalls and verdict
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pbled_pkg::*;

  typedef struct packed {
    idx_t pn;
    idx_t pp;
    idx_t pb;
    idx_t bn;
    idx_t bp;
    idx_t bb;
  } tick_t;

  localparam int LIMIT          = 400000;
  localparam int TICKS_PER_SET  = 235;
  localparam int HOLD_AT        = 700;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 10;
  localparam int N_DIRECTED     = 12;

  // fields: preset now/pending/before, bank now/pending/before
  localparam tick_t DIRECTED [N_DIRECTED] = '{
    '{8'd0,   NONE_IDX, NONE_IDX, 8'd0,   NONE_IDX, NONE_IDX},
    '{8'd3,   NONE_IDX, 8'd2,     8'd3,   NONE_IDX, 8'd1},
    '{8'd1,   8'd2,     8'd0,     8'd1,   NONE_IDX, 8'd3},
    '{8'd2,   8'd2,     8'd1,     8'd0,   8'd0,     8'd3},
    '{8'd0,   8'd3,     NONE_IDX, 8'd2,   8'd1,     8'd3},
    '{NONE_IDX, NONE_IDX, NONE_IDX, NONE_IDX, NONE_IDX, NONE_IDX},
    '{8'd4,   NONE_IDX, 8'd7,     8'd200, NONE_IDX, 8'd254},
    '{8'd2,   NONE_IDX, 8'd2,     8'd1,   NONE_IDX, 8'd1},
    '{8'd3,   NONE_IDX, 8'd0,     8'd5,   NONE_IDX, 8'd3},
    '{8'd0,   8'd80,    NONE_IDX, 8'd1,   NONE_IDX, 8'd0},
    '{8'd1,   NONE_IDX, 8'd100,   8'd2,   8'd0,     8'd254},
    '{8'd0,   NONE_IDX, 8'd0,     8'd0,   8'd3,     NONE_IDX}
  };

  logic                  clk_i            = 1'b0;
  logic                  rst_ni           = 1'b0;
  logic                  cfg_we_i         = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i        = CFG_PLAIN;
  logic [CFG_DATA_W-1:0] cfg_data_i       = '0;
  logic                  in_valid_i       = 1'b0;
  logic                  in_stall_o;
  idx_t                  preset_now_i     = '0;
  idx_t                  preset_pending_i = NONE_IDX;
  idx_t                  preset_before_i  = NONE_IDX;
  idx_t                  bank_now_i       = '0;
  idx_t                  bank_pending_i   = NONE_IDX;
  idx_t                  bank_before_i    = NONE_IDX;
  logic                  out_valid_o;
  logic                  out_stall_i      = 1'b0;
  logic [LED_W-1:0]      row_a_leds_o;
  logic [LED_W-1:0]      row_b_leds_o;
  logic [CODE_W-1:0]     selection_code_o;

  int   fail_count;
  int   pending;
  int   checked;
  int   sent_cnt   = 0;
  int   settings   = 0;
  logic quiet      = 1'b0;
  logic calm       = 1'b0;
  logic hold_done  = 1'b0;

  preset_bank_led_indicator_unit dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .preset_now_i     (preset_now_i),
    .preset_pending_i (preset_pending_i),
    .preset_before_i  (preset_before_i),
    .bank_now_i       (bank_now_i),
    .bank_pending_i   (bank_pending_i),
    .bank_before_i    (bank_before_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .row_a_leds_o     (row_a_leds_o),
    .row_b_leds_o     (row_b_leds_o),
    .selection_code_o (selection_code_o)
  );

  led_indicator_checker chk (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .preset_now_i     (preset_now_i),
    .preset_pending_i (preset_pending_i),
    .preset_before_i  (preset_before_i),
    .bank_now_i       (bank_now_i),
    .bank_pending_i   (bank_pending_i),
    .bank_before_i    (bank_before_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .row_a_leds_i     (row_a_leds_o),
    .row_b_leds_i     (row_b_leds_o),
    .selection_code_i (selection_code_o),
    .fail_count_o     (fail_count),
    .pending_o        (pending),
    .checked_o        (checked)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic idx_t maybe_idx(input int none_pct);
    if ($urandom_range(0, 99) < none_pct) return NONE_IDX;
    return idx_t'($urandom_range(0, 3));
  endfunction

  function automatic idx_t noise_idx();
    case ($urandom_range(0, 3))
      0:       return idx_t'($urandom);
      1:       return idx_t'($urandom_range(4, 254));
      2:       return NONE_IDX;
      default: return idx_t'($urandom_range(0, 3));
    endcase
  endfunction

  // mostly well-formed ticks, a quarter noise
  function automatic tick_t make_tick();
    tick_t t;
    if ($urandom_range(0, 3) != 0) begin
      t.pn = maybe_idx(0);
      t.pp = maybe_idx(50);
      t.pb = maybe_idx(40);
      t.bn = maybe_idx(0);
      t.bp = maybe_idx(50);
      t.bb = maybe_idx(40);
    end else begin
      t.pn = noise_idx();
      t.pp = noise_idx();
      t.pb = noise_idx();
      t.bn = noise_idx();
      t.bp = noise_idx();
      t.bb = noise_idx();
    end
    return t;
  endfunction

  task automatic send_tick(input tick_t t);
    if (!quiet && !calm && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    preset_now_i     <= t.pn;
    preset_pending_i <= t.pp;
    preset_before_i  <= t.pb;
    bank_now_i       <= t.bn;
    bank_pending_i   <= t.bp;
    bank_before_i    <= t.bb;
    do @(posedge clk_i); while (in_stall_o);
    sent_cnt++;
    if (sent_cnt % 40 == 0) calm = ($urandom_range(0, 3) == 0);
  endtask

  // stop offering items and wait until every result is back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic plain, input logic bar, input logic rot);
    drain_results();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_PLAIN;
    cfg_data_i <= plain;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_BAR;
    cfg_data_i <= bar;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_ROT;
    cfg_data_i <= rot;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    settings++;
  endtask

  // receiver: random stall bursts, one long hold-off, nothing in the last part
  initial begin
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (!hold_done && sent_cnt >= HOLD_AT) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        out_stall_i <= 1'b0;
        hold_done = 1'b1;
      end else if (!quiet && $urandom_range(0, 2) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        repeat ($urandom_range(0, 20)) @(posedge clk_i);
      end
    end
  end

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $error("run did not finish within %0d cycles", LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    logic [2:0] setting;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_cfg(1'b0, 1'b0, 1'b0);
    for (int i = 0; i < N_DIRECTED; i++) send_tick(DIRECTED[i]);
    write_cfg(1'b0, 1'b1, 1'b0);
    for (int i = 0; i < N_DIRECTED; i++) send_tick(DIRECTED[i]);

    for (int k = 0; k < 8; k++) begin
      setting = 3'(k);
      quiet   = (k == 7);
      write_cfg(setting[0], setting[1], setting[2]);
      repeat (TICKS_PER_SET) send_tick(make_tick());
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending != 0) $error("%0d expected results never arrived", pending);
    $display("covered %0d ticks under %0d register settings, %0d results compared",
             sent_cnt, settings, checked);
    $display("mode combinations: point, bar, plain and rotated, with stalls and a long hold-off");
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### preset_bank_led_indicator_unit.f
+incdir+rtl
rtl/pbled_pkg.sv
rtl/pbled_timer.sv
rtl/pbled_row.sv
rtl/preset_bank_led_indicator_unit.sv
rtl/pbled_checker.sv
sim/led_indicator_checker.sv
sim/tb.sv
